>>> src/bcg_pkg.sv
// ----------------------------------------------------------------------------
// bcg_pkg
// shared constants, register indexes and width helpers for the colour gradient
// ----------------------------------------------------------------------------
package bcg_pkg;

  localparam int MAX_DIM_DEF      = 4096;
  localparam int CHANNEL_BITS_DEF = 8;

  // fixed field widths
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int IDX_W      = 3;
  localparam int IN_TDATA_W = 24;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  // bits needed for one axis denominator or position (at least 2, to hold the midpoint case)
  function automatic int ax_width(input int max_dim);
    int lim;
    int w;
    lim = (max_dim < (1 << DIM_W)) ? max_dim : (1 << DIM_W);
    w   = $clog2(lim);
    return (w < 2) ? 2 : w;
  endfunction

endpackage

>>> src/bcg_interp.sv
// ----------------------------------------------------------------------------
// bcg_interp
// four-stage front end: axis setup, edge weighting, row weighting, rounding
// ----------------------------------------------------------------------------
module bcg_interp import bcg_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int AXW  = ax_width(MAX_DIM),
  localparam int DENW = 2 * AXW,
  localparam int NUMW = CHANNEL_BITS + 2 * AXW,
  localparam int RGBW = 3 * CHANNEL_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pix_x,
  input  logic [PIX_W-1:0]  pix_y,
  input  logic [RGBW-1:0]   cfg_tl,
  input  logic [RGBW-1:0]   cfg_tr,
  input  logic [RGBW-1:0]   cfg_bl,
  input  logic [RGBW-1:0]   cfg_br,
  input  logic [DIM_W-1:0]  cfg_width,
  input  logic [DIM_W-1:0]  cfg_height,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3*NUMW-1:0] out_num,
  output logic [DENW-1:0]   out_den
);

  localparam int CB = CHANNEL_BITS;
  localparam int LW = CB + AXW;

  // clamp the size, then give {denominator, position}; a size of one means midpoint
  function automatic logic [2*AXW-1:0] axis_f(input logic [DIM_W-1:0] size,
                                               input logic [PIX_W-1:0] pos);
    logic [DIM_W-1:0] sz;
    logic [DIM_W-1:0] lim;
    logic [AXW-1:0]   d;
    logic [AXW-1:0]   a;
    sz = size;
    if (sz == '0) begin
      sz = DIM_W'(1);
    end else if (32'(sz) > 32'(MAX_DIM)) begin
      sz = DIM_W'(MAX_DIM);
    end
    lim = sz - DIM_W'(1);
    if (sz == DIM_W'(1)) begin
      d = AXW'(2);
      a = AXW'(1);
    end else begin
      d = AXW'(lim);
      a = (DIM_W'(pos) > lim) ? AXW'(lim) : AXW'(pos);
    end
    return {d, a};
  endfunction

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1
  logic [AXW-1:0] wd_nxt, xi_nxt, hd_nxt, yi_nxt;
  logic [AXW-1:0] wd1_r, hd1_r, xi1_r, yi1_r, wx1_r, wy1_r;
  // stage 2
  logic [LW-1:0]   left_nxt  [3];
  logic [LW-1:0]   right_nxt [3];
  logic [LW-1:0]   left2_r   [3];
  logic [LW-1:0]   right2_r  [3];
  logic [DENW-1:0] den2_r;
  logic [AXW-1:0]  wx2_r, xi2_r;
  // stage 3
  logic [NUMW-1:0] sum_nxt [3];
  logic [NUMW-1:0] sum3_r  [3];
  logic [DENW-1:0] den3_r;
  // stage 4
  logic [NUMW-1:0] num4_r [3];
  logic [DENW-1:0] den4_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign {wd_nxt, xi_nxt} = axis_f(cfg_width, pix_x);
  assign {hd_nxt, yi_nxt} = axis_f(cfg_height, pix_y);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      left_nxt[k]  = LW'(cfg_tl[k*CB +: CB]) * LW'(wy1_r)
                   + LW'(cfg_bl[k*CB +: CB]) * LW'(yi1_r);
      right_nxt[k] = LW'(cfg_tr[k*CB +: CB]) * LW'(wy1_r)
                   + LW'(cfg_br[k*CB +: CB]) * LW'(yi1_r);
      sum_nxt[k]   = NUMW'(left2_r[k]) * NUMW'(wx2_r)
                   + NUMW'(right2_r[k]) * NUMW'(xi2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      wd1_r <= wd_nxt;
      hd1_r <= hd_nxt;
      xi1_r <= xi_nxt;
      yi1_r <= yi_nxt;
      wx1_r <= wd_nxt - xi_nxt;
      wy1_r <= hd_nxt - yi_nxt;
    end
    if (rdy2 && v1_r) begin
      left2_r  <= left_nxt;
      right2_r <= right_nxt;
      den2_r   <= DENW'(wd1_r) * DENW'(hd1_r);
      wx2_r    <= wx1_r;
      xi2_r    <= xi1_r;
    end
    if (rdy3 && v2_r) begin
      sum3_r <= sum_nxt;
      den3_r <= den2_r;
    end
    if (rdy4 && v3_r) begin
      // half the denominator gives round to nearest, half up
      for (int k = 0; k < 3; k++) begin
        num4_r[k] <= sum3_r[k] + NUMW'(den3_r >> 1);
      end
      den4_r <= den3_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_num[k*NUMW +: NUMW] = num4_r[k];
    end
  end

  assign out_valid = v4_r;
  assign out_den   = den4_r;

endmodule

>>> src/bcg_div_step.sv
// ----------------------------------------------------------------------------
// bcg_div_step
// one restoring division step for all three channels, one quotient bit each
// ----------------------------------------------------------------------------
module bcg_div_step import bcg_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int STEP         = 0,
  localparam int AXW  = ax_width(MAX_DIM),
  localparam int DENW = 2 * AXW,
  localparam int NUMW = CHANNEL_BITS + 2 * AXW,
  localparam int QW   = 3 * CHANNEL_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3*NUMW-1:0] in_rem,
  input  logic [DENW-1:0]   in_den,
  input  logic [QW-1:0]     in_quo,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3*NUMW-1:0] out_rem,
  output logic [DENW-1:0]   out_den,
  output logic [QW-1:0]     out_quo
);

  logic              v_r;
  logic [3*NUMW-1:0] rem_r, rem_nxt;
  logic [DENW-1:0]   den_r;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [NUMW-1:0]   dsh;

  assign in_ready = !v_r || out_ready;
  assign dsh      = NUMW'(in_den) << STEP;

  // remainder entering this step is below twice the shifted divisor
  always_comb begin
    rem_nxt = in_rem;
    quo_nxt = in_quo;
    for (int k = 0; k < 3; k++) begin
      if (in_rem[k*NUMW +: NUMW] >= dsh) begin
        rem_nxt[k*NUMW +: NUMW]     = in_rem[k*NUMW +: NUMW] - dsh;
        quo_nxt[k*CHANNEL_BITS + STEP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r <= rem_nxt;
      den_r <= in_den;
      quo_r <= quo_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_quo   = quo_r;

endmodule

>>> src/bilinear_color_gradient.sv
// ----------------------------------------------------------------------------
// bilinear_color_gradient
// throughput: one item per cycle while out_tready holds; four interpolation stages, then one division
//   stage per quotient bit, with a ready chain so any bubble can be filled
// reset: corner colours and frame size return to their defaults, pipeline empties
// ----------------------------------------------------------------------------
module bilinear_color_gradient import bcg_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int RGBW  = 3 * CHANNEL_BITS,
  localparam int CFG_W = (RGBW > DIM_W) ? RGBW : DIM_W,
  localparam int OUT_W = ((RGBW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // pixel_x, pixel_y
  // result item
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // red, green, blue, zero pad
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CB   = CHANNEL_BITS;
  localparam int AXW  = ax_width(MAX_DIM);
  localparam int DENW = 2 * AXW;
  localparam int NUMW = CB + 2 * AXW;

  localparam logic [CB-1:0]   CH_MAX = {CB{1'b1}};
  localparam logic [CB-1:0]   CH_MIN = {CB{1'b0}};
  localparam logic [RGBW-1:0] TL_RST = {CH_MAX, CH_MIN, CH_MIN};
  localparam logic [RGBW-1:0] TR_RST = {CH_MIN, CH_MIN, CH_MAX};
  localparam logic [RGBW-1:0] BL_RST = {CH_MAX, CH_MAX, CH_MIN};
  localparam logic [RGBW-1:0] BR_RST = {CH_MIN, CH_MAX, CH_MIN};

  logic [RGBW-1:0]  tl_r, tr_r, bl_r, br_r;
  logic [DIM_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r     <= TL_RST;
      tr_r     <= TR_RST;
      bl_r     <= BL_RST;
      br_r     <= BR_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TOP_LEFT:     tl_r     <= RGBW'(cfg_wdata);
        REG_TOP_RIGHT:    tr_r     <= RGBW'(cfg_wdata);
        REG_BOTTOM_LEFT:  bl_r     <= RGBW'(cfg_wdata);
        REG_BOTTOM_RIGHT: br_r     <= RGBW'(cfg_wdata);
        REG_FRAME_WIDTH:  width_r  <= DIM_W'(cfg_wdata);
        REG_FRAME_HEIGHT: height_r <= DIM_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // division chain, index 0 is the front end output
  logic              vld   [CB+1];
  logic              rdy   [CB+1];
  logic [3*NUMW-1:0] rem_c [CB+1];
  logic [DENW-1:0]   den_c [CB+1];
  logic [RGBW-1:0]   quo_c [CB+1];

  bcg_interp #(
    .MAX_DIM      (MAX_DIM),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .pix_x      (in_tdata[PIX_W-1:0]),
    .pix_y      (in_tdata[2*PIX_W-1:PIX_W]),
    .cfg_tl     (tl_r),
    .cfg_tr     (tr_r),
    .cfg_bl     (bl_r),
    .cfg_br     (br_r),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .out_valid  (vld[0]),
    .out_ready  (rdy[0]),
    .out_num    (rem_c[0]),
    .out_den    (den_c[0])
  );

  assign quo_c[0] = '0;

  // quotient bits from the top down
  for (genvar g = 0; g < CB; g++) begin : g_div
    bcg_div_step #(
      .MAX_DIM      (MAX_DIM),
      .CHANNEL_BITS (CHANNEL_BITS),
      .STEP         (CB - 1 - g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_rem    (rem_c[g]),
      .in_den    (den_c[g]),
      .in_quo    (quo_c[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_rem   (rem_c[g+1]),
      .out_den   (den_c[g+1]),
      .out_quo   (quo_c[g+1])
    );
  end

  assign rdy[CB]    = out_tready;
  assign out_tvalid = vld[CB];
  // quotient holds blue low, red high; the stream puts red first
  assign out_tdata  = OUT_W'({quo_c[CB][0 +: CB], quo_c[CB][CB +: CB], quo_c[CB][2*CB +: CB]});

  // a ready sink must never stall the input side
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while result side ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a finished division leaves each remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rem_c[CB][0 +: NUMW] < NUMW'(den_c[CB]))
                && (rem_c[CB][NUMW +: NUMW] < NUMW'(den_c[CB]))
                && (rem_c[CB][2*NUMW +: NUMW] < NUMW'(den_c[CB])))
    else $error("division remainder not below divisor");

endmodule
